// ===== src/arbb_pkg.sv =====
`default_nettype none

package arbb_pkg;

    // coordinate range after saturation and fraction bits of the coefficients
    localparam int COORD_BITS     = 24;
    localparam int COEF_FRAC_BITS = 16;

    // fixed field widths
    localparam int COEF_W = 24;
    localparam int IN_W   = 24;
    localparam int SIZE_W = 23;
    localparam int OUT_W  = 24;

    // internal widths
    localparam int EDGE_W    = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;
    localparam int PROD_W    = COEF_W + EDGE_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int SHR_W     = ACC_W - COEF_FRAC_BITS;
    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int OFF_SHIFT = 8;

    localparam longint COORD_MAX  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);
    localparam longint EXTENT_MAX = (longint'(1) <<< OUT_W) - 1;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd65536;

    // per-stage load enables of the axis pipeline
    typedef struct packed {
        logic prod;
        logic pick;
        logic sum;
        logic clamp;
    } arbb_adv_t;

endpackage

`default_nettype wire

// ===== src/arbb_axis.sv =====
`default_nettype none

// one output axis: the mapped value is separable in u and v, and rounding and
// clamping are monotonic, so the corner extremes come from the term extremes
module arbb_axis
    import arbb_pkg::*;
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire arbb_adv_t                adv,
    input  wire logic signed [COEF_W-1:0] coef_u,
    input  wire logic signed [COEF_W-1:0] coef_v,
    input  wire logic signed [COEF_W-1:0] offset,
    input  wire logic signed [EDGE_W-1:0] u0,
    input  wire logic signed [EDGE_W-1:0] u1,
    input  wire logic signed [EDGE_W-1:0] v0,
    input  wire logic signed [EDGE_W-1:0] v1,
    output logic signed [COORD_BITS-1:0]  lo,
    output logic signed [COORD_BITS-1:0]  hi,
    output logic                          sat
);

    logic signed [PROD_W-1:0]     pu0_reg, pu1_reg, pv0_reg, pv1_reg;
    logic signed [PROD_W-1:0]     su_lo_reg, su_hi_reg, sv_lo_reg, sv_hi_reg;
    logic signed [ACC_W-1:0]      acc_lo_reg, acc_hi_reg;
    logic signed [COORD_BITS-1:0] lo_reg, hi_reg;
    logic                         sat_reg;

    logic signed [ACC_W-1:0]      off_term;
    logic signed [ACC_W-1:0]      acc_lo_next, acc_hi_next;
    logic signed [SHR_W-1:0]      sh_lo, sh_hi;
    logic signed [SHR_W-1:0]      lim_max, lim_min;
    logic signed [COORD_BITS-1:0] lo_next, hi_next;
    logic                         sat_next;

    // products
    always_ff @(posedge clk)
    begin
        if (adv.prod)
        begin
            pu0_reg <= PROD_W'(coef_u) * PROD_W'(u0);
            pu1_reg <= PROD_W'(coef_u) * PROD_W'(u1);
            pv0_reg <= PROD_W'(coef_v) * PROD_W'(v0);
            pv1_reg <= PROD_W'(coef_v) * PROD_W'(v1);
        end
    end

    // smaller and larger term of each input axis
    always_ff @(posedge clk)
    begin
        if (adv.pick)
        begin
            su_lo_reg <= (pu0_reg < pu1_reg) ? pu0_reg : pu1_reg;
            su_hi_reg <= (pu0_reg < pu1_reg) ? pu1_reg : pu0_reg;
            sv_lo_reg <= (pv0_reg < pv1_reg) ? pv0_reg : pv1_reg;
            sv_hi_reg <= (pv0_reg < pv1_reg) ? pv1_reg : pv0_reg;
        end
    end

    // offset is q.16, products are q.24
    assign off_term    = ACC_W'(offset) <<< OFF_SHIFT;
    assign acc_lo_next = ACC_W'(su_lo_reg) + ACC_W'(sv_lo_reg) + off_term
                         + ACC_W'(ROUND_HALF);
    assign acc_hi_next = ACC_W'(su_hi_reg) + ACC_W'(sv_hi_reg) + off_term
                         + ACC_W'(ROUND_HALF);

    always_ff @(posedge clk)
    begin
        if (adv.sum)
        begin
            acc_lo_reg <= acc_lo_next;
            acc_hi_reg <= acc_hi_next;
        end
    end

    // floor shift then clamp to the coordinate range
    assign sh_lo   = $signed(acc_lo_reg[ACC_W-1:COEF_FRAC_BITS]);
    assign sh_hi   = $signed(acc_hi_reg[ACC_W-1:COEF_FRAC_BITS]);
    assign lim_max = SHR_W'(COORD_MAX);
    assign lim_min = SHR_W'(COORD_MIN);

    always_comb
    begin
        sat_next = 1'b0;
        if (sh_lo > lim_max)
        begin
            lo_next  = COORD_BITS'(COORD_MAX);
            sat_next = 1'b1;
        end
        else if (sh_lo < lim_min)
        begin
            lo_next  = COORD_BITS'(COORD_MIN);
            sat_next = 1'b1;
        end
        else
        begin
            lo_next = sh_lo[COORD_BITS-1:0];
        end
        if (sh_hi > lim_max)
        begin
            hi_next  = COORD_BITS'(COORD_MAX);
            sat_next = 1'b1;
        end
        else if (sh_hi < lim_min)
        begin
            hi_next  = COORD_BITS'(COORD_MIN);
            sat_next = 1'b1;
        end
        else
        begin
            hi_next = sh_hi[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (adv.clamp)
        begin
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.clamp)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo  = lo_reg;
    assign hi  = hi_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// ===== src/affine_rect_bounding_box.sv =====
// Affine bounding box of a rectangle.
// Input stream s_*: one rectangle per transaction (left, top, width, height).
// Output stream m_*: the axis-aligned box of its four corners after mapping
// through the 2x3 matrix, with a clipped flag in m_tuser.
// The matrix sits in six registers written over the cfg_* channel (index 0..5:
// coef_xx, coef_xy, offset_x, coef_yx, coef_yy, offset_y); an index above 5 is
// dropped. cfg_ready is always high; write only while the pipeline is empty.
// One rectangle per cycle while the receiver does not stall: the six register
// stages (edge sums, multipliers, term pick, accumulate, round and clamp,
// extent) each take one item per clock unless stalled.
// Each stage holds its own valid bit and loads when the stage after it is
// empty or moving, so a stalled receiver only fills the pipeline; s_tready
// drops once every stage holds an item. Nothing is lost or repeated.
// Reset empties the pipeline and loads the identity matrix.
`default_nettype none

module affine_rect_bounding_box
    import arbb_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [95:0] s_tdata,   // rect_left, rect_top, rect_width, rect_height, pad
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [95:0] m_tdata,  // box_left, box_top, box_width, box_height
    output logic [0:0] m_tuser,   // clipped
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [COEF_W-1:0]    cfg_data
);

    logic signed [COEF_W-1:0] coef_xx_reg, coef_xy_reg, offset_x_reg;
    logic signed [COEF_W-1:0] coef_yx_reg, coef_yy_reg, offset_y_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    logic signed [IN_W-1:0]   in_left, in_top;
    logic        [SIZE_W-1:0] in_width, in_height;

    logic signed [EDGE_W-1:0] left_reg, right_reg, top_reg, bottom_reg;
    logic signed [EDGE_W-1:0] right_next, bottom_next;
    logic signed [EDGE_W:0]   right_sum, bottom_sum, lim_max, lim_min;
    logic                     eflag_reg, eflag_next;
    logic                     ef2_reg, ef3_reg, ef4_reg, ef5_reg;

    arbb_adv_t adv;

    logic signed [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi;
    logic                         x_sat, y_sat;

    logic [DIFF_W-1:0] diff_x, diff_y;
    logic [63:0]       ext_x, ext_y, ext_left, ext_top;
    logic              wide_x, wide_y;

    logic [OUT_W-1:0] box_left_reg, box_top_reg, box_width_reg, box_height_reg;
    logic             clipped_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg  <= COEF_ONE;
            coef_xy_reg  <= '0;
            offset_x_reg <= '0;
            coef_yx_reg  <= '0;
            coef_yy_reg  <= COEF_ONE;
            offset_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COEF_XX:  coef_xx_reg  <= $signed(cfg_data);
                REG_COEF_XY:  coef_xy_reg  <= $signed(cfg_data);
                REG_OFFSET_X: offset_x_reg <= $signed(cfg_data);
                REG_COEF_YX:  coef_yx_reg  <= $signed(cfg_data);
                REG_COEF_YY:  coef_yy_reg  <= $signed(cfg_data);
                REG_OFFSET_Y: offset_y_reg <= $signed(cfg_data);
                default:      ;
            endcase
        end
    end

    // stage handshake: a stage loads when it is empty or its successor loads
    assign rdy6 = !out_valid_reg || m_tready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign adv.prod  = rdy2;
    assign adv.pick  = rdy3;
    assign adv.sum   = rdy4;
    assign adv.clamp = rdy5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) out_valid_reg <= v5_reg;
        end
    end

    // stage 1: far edges, clamped to the coordinate range
    assign in_left   = $signed(s_tdata[23:0]);
    assign in_top    = $signed(s_tdata[47:24]);
    assign in_width  = s_tdata[70:48];
    assign in_height = s_tdata[93:71];

    assign right_sum  = (EDGE_W+1)'(in_left) + $signed((EDGE_W+1)'(in_width));
    assign bottom_sum = (EDGE_W+1)'(in_top) + $signed((EDGE_W+1)'(in_height));
    assign lim_max    = (EDGE_W+1)'(COORD_MAX);
    assign lim_min    = (EDGE_W+1)'(COORD_MIN);

    always_comb
    begin
        eflag_next = 1'b0;
        if (right_sum > lim_max)
        begin
            right_next = EDGE_W'(COORD_MAX);
            eflag_next = 1'b1;
        end
        else if (right_sum < lim_min)
        begin
            right_next = EDGE_W'(COORD_MIN);
            eflag_next = 1'b1;
        end
        else
        begin
            right_next = right_sum[EDGE_W-1:0];
        end
        if (bottom_sum > lim_max)
        begin
            bottom_next = EDGE_W'(COORD_MAX);
            eflag_next  = 1'b1;
        end
        else if (bottom_sum < lim_min)
        begin
            bottom_next = EDGE_W'(COORD_MIN);
            eflag_next  = 1'b1;
        end
        else
        begin
            bottom_next = bottom_sum[EDGE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            left_reg   <= EDGE_W'(in_left);
            top_reg    <= EDGE_W'(in_top);
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
        end
    end

    // edge clamp flag rides alongside the axis pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eflag_reg <= 1'b0;
            ef2_reg   <= 1'b0;
            ef3_reg   <= 1'b0;
            ef4_reg   <= 1'b0;
            ef5_reg   <= 1'b0;
        end
        else
        begin
            if (rdy1) eflag_reg <= eflag_next;
            if (rdy2) ef2_reg   <= eflag_reg;
            if (rdy3) ef3_reg   <= ef2_reg;
            if (rdy4) ef4_reg   <= ef3_reg;
            if (rdy5) ef5_reg   <= ef4_reg;
        end
    end

    // stages 2 to 5
    arbb_axis u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .coef_u (coef_xx_reg),
        .coef_v (coef_xy_reg),
        .offset (offset_x_reg),
        .u0     (left_reg),
        .u1     (right_reg),
        .v0     (top_reg),
        .v1     (bottom_reg),
        .lo     (x_lo),
        .hi     (x_hi),
        .sat    (x_sat)
    );

    arbb_axis u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .coef_u (coef_yx_reg),
        .coef_v (coef_yy_reg),
        .offset (offset_y_reg),
        .u0     (left_reg),
        .u1     (right_reg),
        .v0     (top_reg),
        .v1     (bottom_reg),
        .lo     (y_lo),
        .hi     (y_hi),
        .sat    (y_sat)
    );

    // stage 6: extents and output register
    assign diff_x   = DIFF_W'(x_hi) - DIFF_W'(x_lo);
    assign diff_y   = DIFF_W'(y_hi) - DIFF_W'(y_lo);
    assign ext_x    = 64'(diff_x);
    assign ext_y    = 64'(diff_y);
    assign wide_x   = ext_x > 64'(EXTENT_MAX);
    assign wide_y   = ext_y > 64'(EXTENT_MAX);
    assign ext_left = 64'(x_lo);
    assign ext_top  = 64'(y_lo);

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            box_left_reg   <= ext_left[OUT_W-1:0];
            box_top_reg    <= ext_top[OUT_W-1:0];
            box_width_reg  <= wide_x ? OUT_W'(EXTENT_MAX) : ext_x[OUT_W-1:0];
            box_height_reg <= wide_y ? OUT_W'(EXTENT_MAX) : ext_y[OUT_W-1:0];
            clipped_reg    <= ef5_reg | x_sat | y_sat | wide_x | wide_y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {box_height_reg, box_width_reg, box_top_reg, box_left_reg};
    assign m_tuser  = clipped_reg;

`ifndef ASSERT_OFF
    a_empty_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_tready)
        else $error("front stage empty but input not ready");

    a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted transaction missing from first stage");

    a_bubble_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("last stage item not moved into empty output");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && v5_reg) |=> v5_reg)
        else $error("item dropped from last stage during stall");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import arbb_pkg::*;

    localparam int     FRAC_SHIFT   = 16;
    localparam longint HALF_LSB     = 64'sd32768;
    localparam longint SAT_HI       = 64'sd8388607;
    localparam longint SAT_LO       = -64'sd8388608;
    localparam longint SPAN_MAX     = 64'sd16777215;
    localparam int     IDLE_MAX     = 18;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     NUM_MAT_REGS = 6;
    localparam int     RX_HOLD      = 120;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t UNITY    = 24'sd65536;
    localparam coef_t COEF_TOP = 24'sh7FFFFF;
    localparam coef_t COEF_BOT = 24'sh800000;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] top;
        logic [22:0]        width;
        logic [22:0]        height;
    } rect_t;

    typedef struct {
        logic [23:0] left;
        logic [23:0] top;
        logic [23:0] width;
        logic [23:0] height;
        logic        clipped;
    } box_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [95:0]          s_tdata;   // rect_left, rect_top, rect_width, rect_height, pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [95:0]          m_tdata;   // box_left, box_top, box_width, box_height
    logic [0:0]           m_tuser;   // clipped
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    coef_t matrix [NUM_MAT_REGS];
    box_t  box_q [$];
    int    errors;
    int    rects_sent;
    int    boxes_checked;
    int    boxes_clipped;
    int    settings_used;
    bit    no_idle;
    int    rx_hold_cycles;

    affine_rect_bounding_box u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #(10_000_000);
        $display("timeout with %0d boxes outstanding", box_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint clamp_coord(longint v, inout bit clip);
        if (v > SAT_HI)
        begin
            clip = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            clip = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // exact sum in q.24, round half up, floor shift back to q16.8
    function automatic longint map_axis(coef_t wx, coef_t wy, coef_t off,
                                        longint x, longint y, inout bit clip);
        longint acc;
        acc = longint'(wx) * x + longint'(wy) * y + (longint'(off) <<< 8) + HALF_LSB;
        return clamp_coord(acc >>> FRAC_SHIFT, clip);
    endfunction

    function automatic box_t bound_rect(rect_t r);
        longint xs [2];
        longint ys [2];
        longint px, py, lo_x, hi_x, lo_y, hi_y, span_x, span_y;
        bit     clip;
        box_t   b;
        clip  = 1'b0;
        xs[0] = r.left;
        ys[0] = r.top;
        xs[1] = clamp_coord(xs[0] + longint'(r.width), clip);
        ys[1] = clamp_coord(ys[0] + longint'(r.height), clip);
        lo_x  = SAT_HI;
        hi_x  = SAT_LO;
        lo_y  = SAT_HI;
        hi_y  = SAT_LO;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                px = map_axis(matrix[REG_COEF_XX], matrix[REG_COEF_XY],
                              matrix[REG_OFFSET_X], xs[i], ys[j], clip);
                py = map_axis(matrix[REG_COEF_YX], matrix[REG_COEF_YY],
                              matrix[REG_OFFSET_Y], xs[i], ys[j], clip);
                if (px < lo_x) lo_x = px;
                if (px > hi_x) hi_x = px;
                if (py < lo_y) lo_y = py;
                if (py > hi_y) hi_y = py;
            end
        end
        span_x = hi_x - lo_x;
        span_y = hi_y - lo_y;
        if (span_x > SPAN_MAX)
        begin
            span_x = SPAN_MAX;
            clip   = 1'b1;
        end
        if (span_y > SPAN_MAX)
        begin
            span_y = SPAN_MAX;
            clip   = 1'b1;
        end
        b.left    = lo_x[23:0];
        b.top     = lo_y[23:0];
        b.width   = span_x[23:0];
        b.height  = span_y[23:0];
        b.clipped = clip;
        return b;
    endfunction

    function automatic rect_t mk_rect(logic [23:0] left, logic [23:0] top,
                                      logic [22:0] w, logic [22:0] h);
        rect_t r;
        r.left   = left;
        r.top    = top;
        r.width  = w;
        r.height = h;
        return r;
    endfunction

    function automatic logic [23:0] pick_edge();
        case ($urandom_range(0, 3))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    function automatic rect_t rand_rect();
        rect_t r;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                r.left   = 24'($urandom);
                r.top    = 24'($urandom);
                r.width  = 23'($urandom);
                r.height = 23'($urandom);
            end
            2, 3:
            begin
                // sprite-sized rectangles near the origin
                r.left   = 24'($urandom_range(0, 131072) - 65536);
                r.top    = 24'($urandom_range(0, 131072) - 65536);
                r.width  = 23'($urandom_range(0, 4096));
                r.height = 23'($urandom_range(0, 4096));
            end
            4:
            begin
                r.left   = 24'($urandom);
                r.top    = 24'($urandom);
                r.width  = '0;
                r.height = '0;
            end
            default:
            begin
                r.left   = pick_edge();
                r.top    = pick_edge();
                r.width  = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h000000;
                r.height = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h000000;
            end
        endcase
        return r;
    endfunction

    function automatic coef_t rand_coef();
        case ($urandom_range(0, 5))
            0:       return coef_t'($urandom);
            1:       return COEF_TOP;
            2:       return COEF_BOT;
            3:       return coef_t'($urandom_range(0, 262144)) - 24'sd131072;
            4:       return '0;
            default: return coef_t'($urandom_range(0, 2048)) - 24'sd1024 + UNITY;
        endcase
    endfunction

    task automatic send_rect(rect_t r);
        int   gap;
        box_t want;
        gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        want = bound_rect(r);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.height, r.width, r.top, r.left};
        do @(posedge clk); while (!s_tready);
        box_q.push_back(want);
        rects_sent++;
    endtask

    // sender stops until every outstanding box has been checked
    task automatic wait_boxes();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (box_q.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coef_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= REG_OFFSET_Y)
            matrix[idx] = val;
    endtask

    task automatic load_matrix(coef_t m [NUM_MAT_REGS], bit stray);
        logic [CFG_IDX_W-1:0] idx;
        for (int k = 0; k < NUM_MAT_REGS; k++)
            write_reg(k[CFG_IDX_W-1:0], m[k]);
        // indexes past the map must leave the matrix alone
        idx = REG_OFFSET_Y;
        while (stray && idx != '1)
        begin
            idx++;
            write_reg(idx, coef_t'($urandom));
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // receiver: per-transaction stalls plus an optional long hold-off
    initial
    begin
        int wait_n;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            wait_n = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            if (rx_hold_cycles > 0)
            begin
                wait_n += rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (wait_n > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : box_check
        box_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (box_q.size() == 0)
            begin
                $display("%0t ns: unexpected box, expected none, got %h/%b",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = box_q.pop_front();
                check_field("box_left", want.left, m_tdata[23:0]);
                check_field("box_top", want.top, m_tdata[47:24]);
                check_field("box_width", want.width, m_tdata[71:48]);
                check_field("box_height", want.height, m_tdata[95:72]);
                check_field("clipped", {23'd0, want.clipped}, {23'd0, m_tuser[0]});
                boxes_checked++;
                if (m_tuser[0])
                    boxes_clipped++;
            end
        end
    end

    // identity matrix straight out of reset, edge saturation on right and bottom
    task automatic test_reset_matrix();
        send_rect(mk_rect(24'h000000, 24'h000000, 23'h0, 23'h0));
        send_rect(mk_rect(24'h7FFFFF, 24'h7FFFFF, 23'h0, 23'h0));
        send_rect(mk_rect(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF));
        send_rect(mk_rect(24'h7FFFFF, 24'h000100, 23'h1, 23'h0));
        send_rect(mk_rect(24'h000100, 24'h7FFFFF, 23'h0, 23'h1));
        send_rect(mk_rect(24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF, 23'h7FFFFF));
        send_rect(mk_rect(24'h001000, 24'hFFF000, 23'h000800, 23'h002000));
        wait_boxes();
    endtask

    // half weights exercise round half up on both signs; negative weights swap min and max
    task automatic test_rounding();
        coef_t m [NUM_MAT_REGS];
        m[REG_COEF_XX]  = 24'sd32768;
        m[REG_COEF_XY]  = -24'sd32768;
        m[REG_OFFSET_X] = 24'sd1;
        m[REG_COEF_YX]  = -UNITY;
        m[REG_COEF_YY]  = '0;
        m[REG_OFFSET_Y] = -24'sd1;
        load_matrix(m, 1'b1);
        send_rect(mk_rect(24'h000001, 24'h000000, 23'h0, 23'h0));
        send_rect(mk_rect(24'hFFFFFF, 24'h000000, 23'h0, 23'h0));
        send_rect(mk_rect(24'h000003, 24'h000001, 23'h0, 23'h0));
        send_rect(mk_rect(24'hFFFFFD, 24'hFFFFFF, 23'h0, 23'h0));
        send_rect(mk_rect(24'h000A00, 24'h001400, 23'h006400, 23'h003200));
        wait_boxes();
    endtask

    // full-scale weights and offsets push mapped corners away from the origin into saturation
    task automatic test_extreme_matrices();
        coef_t m [NUM_MAT_REGS];
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int k = 0; k < NUM_MAT_REGS; k++)
                m[k] = (pass == 0) ? COEF_TOP : COEF_BOT;
            load_matrix(m, 1'b0);
            send_rect(mk_rect(24'h7FFFFF, 24'h7FFFFF, 23'h0, 23'h0));
            send_rect(mk_rect(24'h800000, 24'h800000, 23'h0, 23'h0));
            send_rect(mk_rect(24'h000000, 24'h000000, 23'h0, 23'h0));
            send_rect(mk_rect(24'h000001, 24'hFFFFFF, 23'h1, 23'h1));
            send_rect(mk_rect(24'h800000, 24'h000000, 23'h7FFFFF, 23'h7FFFFF));
            wait_boxes();
        end
    endtask

    task automatic test_random_matrices();
        coef_t m [NUM_MAT_REGS];
        for (int phase = 0; phase < 8; phase++)
        begin
            no_idle = (phase % 3 == 2);
            for (int k = 0; k < NUM_MAT_REGS; k++)
                m[k] = rand_coef();
            load_matrix(m, phase == 4);
            for (int n = 0; n < 55; n++)
                send_rect(rand_rect());
            wait_boxes();
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while rectangles keep coming, so the pipeline fills and s_tready drops
    task automatic test_backpressure();
        no_idle        = 1'b1;
        rx_hold_cycles = RX_HOLD;
        for (int n = 0; n < 30; n++)
            send_rect(rand_rect());
        wait_boxes();
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        errors         = 0;
        rects_sent     = 0;
        boxes_checked  = 0;
        boxes_clipped  = 0;
        settings_used  = 1;
        no_idle        = 1'b0;
        rx_hold_cycles = 0;
        matrix[REG_COEF_XX]  = UNITY;
        matrix[REG_COEF_XY]  = '0;
        matrix[REG_OFFSET_X] = '0;
        matrix[REG_COEF_YX]  = '0;
        matrix[REG_COEF_YY]  = UNITY;
        matrix[REG_OFFSET_Y] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix();
        test_rounding();
        test_extreme_matrices();
        test_random_matrices();
        test_backpressure();

        wait_boxes();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run: %0d rectangles under %0d matrix settings, %0d boxes checked",
                 rects_sent, settings_used, boxes_checked);
        $display("run: %0d boxes flagged as clipped, %0d mismatches", boxes_clipped, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== affine_rect_bounding_box.f =====
src/arbb_pkg.sv
src/arbb_axis.sv
src/affine_rect_bounding_box.sv
sim/tb_top.sv
